// ===== design/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with removal.
// No dependencies; every other design file but bdq_ram imports this package.
package bdq_pkg;

  localparam int OP_W         = 3;
  localparam int VALUE_PORT_W = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    walk_start;
    logic    walk_step;
    logic    drop;
    logic    rd_en;
    logic    rd_back;
    logic    cap_front;
    logic    cap_back;
    logic    emit;
    status_t code;
  } bdq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            count_is_one;
    logic            walk_last;
    logic            found;
    logic            out_free;
  } bdq_stat_t;

endpackage

// ===== design/bdq_req_if.sv =====
// Request channel: valid/ready handshake with operation and value.
// Depends on bdq_pkg.
interface bdq_req_if import bdq_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [OP_W-1:0]                operation;
  logic signed [VALUE_PORT_W-1:0] value;

  modport source(output valid, output operation, output value, input ready);
  modport sink(input valid, input operation, input value, output ready);
endinterface

// ===== design/bdq_rsp_if.sv =====
// Response channel: valid/ready handshake with status, count, front and back.
// Depends on bdq_pkg.
interface bdq_rsp_if import bdq_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic [STATUS_W-1:0]            status;
  logic [COUNT_OUT_W-1:0]         entry_count;
  logic signed [VALUE_PORT_W-1:0] front_value;
  logic signed [VALUE_PORT_W-1:0] back_value;

  modport source(output valid, output status, output entry_count, output front_value,
                 output back_value, input ready);
  modport sink(input valid, input status, input entry_count, input front_value,
               input back_value, output ready);
endinterface

// ===== design/bounded_deque_with_remove.sv =====
// Bounded double-ended queue of up to CAPACITY values with removal by value.
// Each request (push front, push back, pop front, pop back, remove first
// match counted from the front) returns one item: status (ok, empty, full,
// not found), the count afterwards, and the front and back values (zero when
// the queue is empty). Values are held in a ring buffer in one RAM; the front
// and back values are kept in registers so pushes need no read. Requests are
// handled one at a time by the controller. A pop that leaves entries behind
// takes the new front or back from a registered RAM read. Remove walks the
// entries through the single RAM read port one per cycle and shifts the tail
// up through the write port behind it; when the value is found and entries
// remain, it then refreshes the front and back with registered reads.
// A new request is taken while the previous result still waits in the
// output register. No clearing pass after reset: only written entries are
// ever read.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl, bdq_datapath.
module bounded_deque_with_remove import bdq_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  // Sequencer: decode, walk, refresh reads, result hand-off.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Ring pointers, entry store, caches and result register.
  bdq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (req.operation),
    .value      (req.value),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.entry_count),
    .rsp_front  (rsp.front_value),
    .rsp_back   (rsp.back_value)
  );

  // One item in flight: an accepted request closes the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // A push is never carried out on a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |-> !stat.full)
    else $error("push on full queue");

  // Full reports carry the full count; empty reports carry zero.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == COUNT_OUT_W'(CAPACITY)))
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
    else $error("empty status with nonzero count");

endmodule

// ===== design/bdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bdq_datapath.sv =====
// Deque datapath: ring pointers, entry store, front/back caches, removal walk
// and the result register. Depends on bdq_pkg and bdq_ram.
module bdq_datapath import bdq_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bdq_cmd_t                       cmd,
  output bdq_stat_t                      stat,
  input  logic [OP_W-1:0]                operation,
  input  logic signed [VALUE_PORT_W-1:0] value,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [STATUS_W-1:0]            rsp_status,
  output logic [COUNT_OUT_W-1:0]         rsp_count,
  output logic signed [VALUE_PORT_W-1:0] rsp_front,
  output logic signed [VALUE_PORT_W-1:0] rsp_back
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [OP_W-1:0]        op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [PW-1:0]          front_pos;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] front_val;
  logic [VALUE_WIDTH-1:0] back_val;
  logic [CW-1:0]          issue_pos;
  logic [CW-1:0]          data_pos;
  logic                   data_valid;
  logic                   found;
  logic                   out_valid;

  logic [63:0]            val_wide;
  logic                   empty;
  logic [PW-1:0]          front_dec;
  logic [PW-1:0]          front_inc;
  logic                   issue;
  logic                   walk_wr;
  logic                   hit;
  logic [CW-1:0]          rd_k;
  logic [CW-1:0]          wr_k;
  logic                   ram_we;
  logic [PW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [PW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Ring slot of logical position k.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(k);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [VALUE_PORT_W-1:0] to_port(input logic [VALUE_WIDTH-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[VALUE_PORT_W-1:0];
  endfunction

  assign val_wide  = {32'd0, value};
  assign empty     = (count == '0);
  assign front_dec = (front_pos == '0) ? PW'(CAPACITY - 1) : front_pos - PW'(1);
  assign front_inc = (front_pos == PW'(CAPACITY - 1)) ? '0 : front_pos + PW'(1);

  assign issue   = cmd.walk_step && (issue_pos < count);
  assign walk_wr = cmd.walk_step && data_valid && found;
  assign hit     = data_valid && !found && (ram_rdata == val_q);

  assign rd_k = cmd.walk_step ? issue_pos : (cmd.rd_back ? count - CW'(1) : '0);
  assign wr_k = cmd.push_back ? count : data_pos - CW'(1);

  // Walk shifts each entry behind the match up by one place.
  assign ram_we    = cmd.push_front || cmd.push_back || walk_wr;
  assign ram_waddr = cmd.push_front ? front_dec : slot_of(front_pos, wr_k);
  assign ram_wdata = walk_wr ? ram_rdata : val_q;
  assign ram_re    = issue || cmd.rd_en;
  assign ram_raddr = slot_of(front_pos, rd_k);

  bdq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_pos  <= '0;
      count      <= '0;
      issue_pos  <= '0;
      data_valid <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      priority if (cmd.push_front) begin
        front_pos <= front_dec;
        count     <= count + CW'(1);
      end else if (cmd.push_back) begin
        count <= count + CW'(1);
      end else if (cmd.pop_front) begin
        front_pos <= front_inc;
        count     <= count - CW'(1);
      end else if (cmd.pop_back || cmd.drop) begin
        count <= count - CW'(1);
      end else begin
        count <= count;
      end

      if (cmd.walk_start) begin
        issue_pos  <= '0;
        data_valid <= 1'b0;
        found      <= 1'b0;
      end else if (cmd.walk_step) begin
        if (issue) begin
          issue_pos <= issue_pos + CW'(1);
        end
        data_valid <= issue;
        if (hit) begin
          found <= 1'b1;
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      val_q <= val_wide[VALUE_WIDTH-1:0];
    end
    if (cmd.walk_step && issue) begin
      data_pos <= issue_pos;
    end
    if (cmd.push_front) begin
      front_val <= val_q;
      if (empty) begin
        back_val <= val_q;
      end
    end
    if (cmd.push_back) begin
      back_val <= val_q;
      if (empty) begin
        front_val <= val_q;
      end
    end
    if (cmd.cap_front) begin
      front_val <= ram_rdata;
    end
    if (cmd.cap_back) begin
      back_val <= ram_rdata;
    end
    if (cmd.emit) begin
      rsp_status <= cmd.code;
      rsp_count  <= COUNT_OUT_W'(count);
      rsp_front  <= empty ? '0 : to_port(front_val);
      rsp_back   <= empty ? '0 : to_port(back_val);
    end
  end

  assign rsp_valid = out_valid;

  assign stat.op           = op_q;
  assign stat.empty        = empty;
  assign stat.full         = (count == CW'(CAPACITY));
  assign stat.count_is_one = (count == CW'(1));
  assign stat.walk_last    = data_valid && (data_pos == count - CW'(1));
  assign stat.found        = found;
  assign stat.out_free     = !out_valid || rsp_ready;

endmodule

// ===== design/bdq_ctrl.sv =====
// Deque controller: sequences one request at a time through decode, removal
// walk, front/back refresh reads and result hand-off. Depends on bdq_pkg.
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  bdq_stat_t stat,
  output bdq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_WALK_END,
    S_RD_ISSUE,
    S_RD_CAP,
    S_DONE
  } state_t;

  state_t  state;
  status_t code;
  logic    rd_back;
  logic    rd_both;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.code    = code;
    cmd.rd_back = rd_back;
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_DECIDE: begin
        unique case (stat.op)
          OP_PUSH_FRONT: cmd.push_front = !stat.full;
          OP_PUSH_BACK:  cmd.push_back  = !stat.full;
          OP_POP_FRONT:  cmd.pop_front  = !stat.empty;
          OP_POP_BACK:   cmd.pop_back   = !stat.empty;
          OP_REMOVE:     cmd.walk_start = !stat.empty;
          default:       cmd.load       = 1'b0;
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
      end
      S_WALK_END: begin
        cmd.drop = stat.found;
      end
      S_RD_ISSUE: begin
        cmd.rd_en = 1'b1;
      end
      S_RD_CAP: begin
        cmd.cap_front = !rd_back;
        cmd.cap_back  = rd_back;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      code    <= ST_OK;
      rd_back <= 1'b0;
      rd_both <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          code    <= ST_OK;
          rd_both <= 1'b0;
          state   <= S_DONE;
          unique case (stat.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (stat.full) begin
                code <= ST_FULL;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (stat.empty) begin
                code <= ST_EMPTY;
              end else if (!stat.count_is_one) begin
                rd_back <= (stat.op == OP_POP_BACK);
                state   <= S_RD_ISSUE;
              end
            end
            OP_REMOVE: begin
              if (stat.empty) begin
                code <= ST_EMPTY;
              end else begin
                state <= S_WALK;
              end
            end
            default: begin
              code <= ST_OK;
            end
          endcase
        end
        S_WALK: begin
          if (stat.walk_last) begin
            state <= S_WALK_END;
          end
        end
        S_WALK_END: begin
          if (!stat.found) begin
            code  <= ST_MISSING;
            state <= S_DONE;
          end else if (stat.count_is_one) begin
            state <= S_DONE;
          end else begin
            rd_back <= 1'b0;
            rd_both <= 1'b1;
            state   <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_CAP;
        end
        S_RD_CAP: begin
          if (rd_both && !rd_back) begin
            rd_back <= 1'b1;
            state   <= S_RD_ISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for bounded_deque_with_remove: a directed request table, then biased random phases.
// Every result is checked against an in-bench deque model. Needs bdq_pkg, bdq_req_if,
// bdq_rsp_if and the design top.
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 400;      // long response hold-off, fills the block up
  localparam int DRAIN_CYCLES = 100;      // longer than a full-depth remove walk
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_PRINTS   = 100;

  // Operation codes that the block ignores.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_PORT_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_PORT_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum int {PH_FILL, PH_MIX, PH_REMOVE, PH_DRAIN} phase_kind_t;

  // What one result item shows: status, count, front and back.
  typedef struct packed {
    status_t                        status;
    logic [COUNT_OUT_W-1:0]         entry_count;
    logic signed [VALUE_PORT_W-1:0] front_value;
    logic signed [VALUE_PORT_W-1:0] back_value;
  } deque_view_t;

  // One row of the directed table; pinned rows carry their result typed in.
  typedef struct {
    logic [OP_W-1:0]                op;
    logic signed [VALUE_PORT_W-1:0] value;
    bit                             pinned;
    deque_view_t                    view;
  } dir_row_t;

  logic clk;
  logic rst;

  bdq_req_if req_ch();
  bdq_rsp_if rsp_ch();

  bounded_deque_with_remove uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Deque contents as the model sees them, front first.
  logic signed [VALUE_PORT_W-1:0] held_vals[$];
  // Results still owed by the block, oldest first.
  deque_view_t                    owed_views[$];
  deque_view_t                    predicted;

  dir_row_t dir_rows[$];

  int mismatches;
  int results_seen;
  int cycles;

  // Driver side info, stable while valid is high.
  bit          pin_now;
  deque_view_t pin_view;

  int send_gap_max;
  int recv_gap_max;
  bit hold_request;

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Deque model: applies one request, returns the result the block must give.
  // ---------------------------------------------------------------------------
  function automatic deque_view_t apply_request(input logic [OP_W-1:0] op,
                                                input logic signed [VALUE_PORT_W-1:0] val);
    deque_view_t v;
    int          hit;
    int          i;
    v        = '0;
    v.status = ST_OK;
    hit      = -1;
    case (op)
      OP_PUSH_FRONT: begin
        if (held_vals.size() >= DEPTH) v.status = ST_FULL;
        else held_vals.push_front(val);
      end
      OP_PUSH_BACK: begin
        if (held_vals.size() >= DEPTH) v.status = ST_FULL;
        else held_vals.push_back(val);
      end
      OP_POP_FRONT: begin
        if (held_vals.size() == 0) v.status = ST_EMPTY;
        else void'(held_vals.pop_front());
      end
      OP_POP_BACK: begin
        if (held_vals.size() == 0) v.status = ST_EMPTY;
        else void'(held_vals.pop_back());
      end
      OP_REMOVE: begin
        if (held_vals.size() == 0) begin
          v.status = ST_EMPTY;
        end else begin
          // first match counted from the front; later entries close the gap
          for (i = 0; i < held_vals.size() && hit < 0; i++)
            if (held_vals[i] == val) hit = i;
          if (hit < 0) v.status = ST_MISSING;
          else held_vals.delete(hit);
        end
      end
      default: ;  // spare codes: no change, status ok
    endcase
    v.entry_count = COUNT_OUT_W'(held_vals.size());
    if (held_vals.size() != 0) begin
      v.front_value = held_vals[0];
      v.back_value  = held_vals[held_vals.size() - 1];
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH %s", msg);
  endtask

  task automatic check_result();
    deque_view_t want;
    results_seen++;
    if (owed_views.size() == 0) begin
      report_mismatch($sformatf("result %0d: nothing expected", results_seen));
      return;
    end
    want = owed_views.pop_front();
    if (rsp_ch.status !== want.status)
      report_mismatch($sformatf("result %0d status: got %0d want %0d",
                                results_seen, rsp_ch.status, want.status));
    if (rsp_ch.entry_count !== want.entry_count)
      report_mismatch($sformatf("result %0d entry_count: got %0d want %0d",
                                results_seen, rsp_ch.entry_count, want.entry_count));
    if (rsp_ch.front_value !== want.front_value)
      report_mismatch($sformatf("result %0d front_value: got %h want %h",
                                results_seen, rsp_ch.front_value, want.front_value));
    if (rsp_ch.back_value !== want.back_value)
      report_mismatch($sformatf("result %0d back_value: got %h want %h",
                                results_seen, rsp_ch.back_value, want.back_value));
  endtask

  // Result check goes first: a result never belongs to the request taken
  // at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_request(req_ch.operation, req_ch.value);
        owed_views.push_back(pin_now ? pin_view : predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, waits for the handshake.
  // valid stays high straight into the next item when no gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_PORT_W-1:0] val,
                           input bit pin, input deque_view_t view);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.value     = val;
    pin_now          = pin;
    pin_view         = view;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response receiver: random stall per item, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    bit hold_done;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = (recv_gap_max > 0) ? $urandom_range(0, recv_gap_max) : 0;
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic dir_row_t pin_row(input logic [OP_W-1:0] op,
                                       input logic signed [VALUE_PORT_W-1:0] val,
                                       input status_t st, input int cnt,
                                       input logic signed [VALUE_PORT_W-1:0] fv,
                                       input logic signed [VALUE_PORT_W-1:0] bv);
    dir_row_t r;
    r.op                = op;
    r.value             = val;
    r.pinned            = 1'b1;
    r.view.status       = st;
    r.view.entry_count  = COUNT_OUT_W'(cnt);
    r.view.front_value  = fv;
    r.view.back_value   = bv;
    return r;
  endfunction

  function automatic dir_row_t open_row(input logic [OP_W-1:0] op,
                                        input logic signed [VALUE_PORT_W-1:0] val);
    dir_row_t r;
    r.op     = op;
    r.value  = val;
    r.pinned = 1'b0;
    r.view   = '0;
    return r;
  endfunction

  function automatic int draw_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;     // stretch with no idling
      1:       return 4;
      default: return 17;
    endcase
  endfunction

  // Mostly a small pool so removes hit and duplicates occur; some extremes;
  // the rest full 32-bit random so every bit toggles.
  function automatic logic signed [VALUE_PORT_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4, 5: return VALUE_PORT_W'(int'($urandom_range(0, 7)) - 4);
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] draw_op(input phase_kind_t kind);
    int push_pct;
    int pop_pct;
    int r;
    case (kind)
      PH_FILL:   begin push_pct = 85; pop_pct = 6;  end
      PH_MIX:    begin push_pct = 45; pop_pct = 35; end
      PH_REMOVE: begin push_pct = 42; pop_pct = 8;  end
      default:   begin push_pct = 10; pop_pct = 78; end
    endcase
    r = $urandom_range(0, 99);
    if (r < 3) begin
      case ($urandom_range(0, 2))
        0:       return OP_SPARE_5;
        1:       return OP_SPARE_6;
        default: return OP_SPARE_7;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < push_pct)           return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    return OP_REMOVE;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int              sent;
    int              phase;
    int              len;
    phase_kind_t     kind;
    logic [OP_W-1:0] op;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_PUSH_FRONT;
    req_ch.value     = '0;
    pin_now          = 1'b0;
    pin_view         = '0;
    send_gap_max     = 17;
    recv_gap_max     = 17;
    hold_request     = 1'b0;

    // Directed table. Empty-queue requests, spare codes, extremes, removal
    // at front, back and middle, first-of-duplicates removal, and draining
    // back to empty.
    dir_rows.push_back(pin_row(OP_POP_FRONT, '0, ST_EMPTY, 0, '0, '0));
    dir_rows.push_back(pin_row(OP_POP_BACK, '0, ST_EMPTY, 0, '0, '0));
    dir_rows.push_back(pin_row(OP_REMOVE, '0, ST_EMPTY, 0, '0, '0));
    dir_rows.push_back(pin_row(OP_SPARE_5, '1, ST_OK, 0, '0, '0));
    dir_rows.push_back(pin_row(OP_PUSH_BACK, VAL_MAX, ST_OK, 1, VAL_MAX, VAL_MAX));
    dir_rows.push_back(pin_row(OP_PUSH_FRONT, VAL_MIN, ST_OK, 2, VAL_MIN, VAL_MAX));
    dir_rows.push_back(pin_row(OP_REMOVE, 32'sd12345, ST_MISSING, 2, VAL_MIN, VAL_MAX));
    dir_rows.push_back(pin_row(OP_SPARE_6, 32'sd1, ST_OK, 2, VAL_MIN, VAL_MAX));
    dir_rows.push_back(pin_row(OP_PUSH_BACK, '0, ST_OK, 3, VAL_MIN, '0));
    dir_rows.push_back(pin_row(OP_PUSH_BACK, '1, ST_OK, 4, VAL_MIN, '1));
    dir_rows.push_back(pin_row(OP_PUSH_FRONT, '0, ST_OK, 5, '0, '1));
    dir_rows.push_back(pin_row(OP_REMOVE, '0, ST_OK, 4, VAL_MIN, '1));
    dir_rows.push_back(pin_row(OP_REMOVE, '1, ST_OK, 3, VAL_MIN, '0));
    dir_rows.push_back(pin_row(OP_SPARE_7, 32'sh5555_5555, ST_OK, 3, VAL_MIN, '0));
    dir_rows.push_back(open_row(OP_PUSH_FRONT, 32'sh5555_5555));
    dir_rows.push_back(open_row(OP_PUSH_BACK, 32'shAAAA_AAAA));
    dir_rows.push_back(open_row(OP_REMOVE, VAL_MAX));
    dir_rows.push_back(open_row(OP_POP_FRONT, '0));
    dir_rows.push_back(open_row(OP_POP_BACK, '0));
    dir_rows.push_back(open_row(OP_POP_BACK, '0));
    dir_rows.push_back(open_row(OP_POP_FRONT, '0));
    dir_rows.push_back(pin_row(OP_REMOVE, 32'sd5, ST_EMPTY, 0, '0, '0));
    dir_rows.push_back(open_row(OP_PUSH_BACK, 32'sd7));
    dir_rows.push_back(open_row(OP_PUSH_BACK, 32'sd3));
    dir_rows.push_back(open_row(OP_PUSH_BACK, 32'sd7));
    dir_rows.push_back(open_row(OP_REMOVE, 32'sd7));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].view);

    // Random phases cycle fill, mix, remove-heavy and drain, so the queue
    // keeps hitting full and empty. Spare codes do not count as items.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      kind         = phase_kind_t'(phase % 4);
      send_gap_max = draw_gap_limit();
      recv_gap_max = draw_gap_limit();
      if (phase == 1) begin
        // back-pressure: receiver stalls long, sender floods
        hold_request = 1'b1;
        send_gap_max = 0;
      end
      len = $urandom_range(60, 140);
      repeat (len) begin
        op = draw_op(kind);
        send_item(op, draw_value(), 1'b0, '0);
        if (op <= OP_REMOVE) sent++;
      end
      phase++;
    end
    req_ch.valid = 1'b0;

    while (owed_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && owed_views.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
